[src/imu_frame_deframer_macros.svh]
// Assertion macros shared by the deframer checker.
`ifndef IMU_FRAME_DEFRAMER_MACROS_SVH
`define IMU_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define IFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ifd_pkg.sv]
// Types and constants shared by the IMU frame deframer.
package ifd_pkg;

    localparam int FRAME_BYTES = 28;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int QTY_W       = 4;
    localparam int READING_W   = 33;

    localparam logic [7:0] SYNC_FIRST  = 8'h88;
    localparam logic [7:0] SYNC_SECOND = 8'hAF;

    localparam logic [QTY_W-1:0] Q_PRESSURE = 4'd12;

    typedef logic [7:0]                    byte_t;
    typedef logic [FRAME_BYTES-1:0][7:0]   frame_t;
    typedef logic [QTY_W-1:0]              quantity_t;
    typedef logic signed [READING_W-1:0]   reading_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[src/ifd_if.sv]
// Stream interfaces for received bytes and decoded results.
interface ifd_byte_if;
    import ifd_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifd_result_if;
    import ifd_pkg::*;

    logic      valid;
    logic      ready;
    quantity_t quantity;
    reading_t  reading;
    logic      last_of_frame;

    modport source (output valid, output quantity, output reading, output last_of_frame,
                    input ready);
    modport sink (input valid, input quantity, input reading, input last_of_frame,
                  output ready);
endinterface

[src/imu_frame_deframer.sv]
// Top level of the IMU serial frame deframer.
//
// The deframer takes one received byte per transfer on rx, at up to one
// transfer per cycle. It hunts for 0x88, then waits for 0xAF (ignoring any
// other byte), takes the next byte as the payload length, stores the first
// 28 payload bytes and counts the rest, and treats the byte after the payload
// as the frame end whatever its value. Each frame end yields thirteen result
// transfers on res: quantities 0 to 11 carry signed big-endian 16-bit words
// from byte pairs of the store (accel, gyro and mag xyz, then roll and pitch
// in hundredths of a degree and yaw in tenths), and quantity 12 carries the
// unsigned little-endian 32-bit pressure with last_of_frame set. Bytes that a
// short frame does not write keep their previous values, zero after reset.
// At the frame end the parser copies the store into a two-entry frame
// queue, and the result stage then delivers one result per cycle while
// res is ready, from registers loaded from the oldest queued frame.
// The closing byte is held off only while both queue entries still hold
// frames that are being delivered, which happens when frames shorter than
// thirteen bytes arrive back to back or when the result side stalls.
module imu_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    ifd_byte_if.sink     rx,
    ifd_result_if.source res
);
    import ifd_pkg::*;

    logic          push;
    logic          pop;
    frame_t        frame;
    frame_t        head;
    queue_status_t q_status;

    // Front end: parses bytes and snapshots the store at each frame end.
    ifd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_status (q_status),
        .push     (push),
        .frame    (frame)
    );

    // Decouples the byte stream from result delivery.
    ifd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (frame),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Back end: walks the thirteen quantities of the oldest queued frame.
    ifd_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .res      (res)
    );

endmodule

[src/ifd_parser.sv]
// Front end: sync hunt, length capture and payload store.
module ifd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    ifd_byte_if.sink              rx,
    input  ifd_pkg::queue_status_t q_status,
    output logic                  push,
    output ifd_pkg::frame_t       frame
);
    import ifd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SOF,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t phase_reg, phase_next;
    byte_t  len_reg, len_next;
    byte_t  index_reg, index_next;
    frame_t store_reg, store_next;

    logic closing;
    logic accept;

    assign closing  = (phase_reg == PH_DATA) && (index_reg == len_reg);
    assign rx.ready = !(closing && q_status.full);
    assign accept   = rx.valid && rx.ready;
    assign push     = accept && closing;
    assign frame    = store_reg;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        index_next = index_reg;
        store_next = store_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx.rx_byte == SYNC_FIRST)
                        phase_next = PH_SOF;
                end
                PH_SOF:
                begin
                    if (rx.rx_byte == SYNC_SECOND)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = rx.rx_byte;
                    index_next = '0;
                    phase_next = PH_DATA;
                end
                default:
                begin
                    if (closing)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // Bytes past the decoded region are counted only.
                        if (index_reg < 8'(FRAME_BYTES))
                            store_next[index_reg[IDX_W-1:0]] = rx.rx_byte;
                        index_next = index_reg + 8'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            index_reg <= '0;
            store_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            index_reg <= index_next;
            store_reg <= store_next;
        end
    end

endmodule

[src/ifd_queue.sv]
// Two-entry queue of closed frame snapshots.
module ifd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ifd_pkg::frame_t        push_frame,
    input  logic                   pop,
    output ifd_pkg::frame_t        head,
    output ifd_pkg::queue_status_t status
);
    import ifd_pkg::*;

    frame_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

[src/ifd_emitter.sv]
// Back end: decodes the head frame into thirteen registered results.
module ifd_emitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ifd_pkg::frame_t        head,
    input  ifd_pkg::queue_status_t q_status,
    output logic                   pop,
    ifd_result_if.source           res
);
    import ifd_pkg::*;

    quantity_t qty_reg, qty_next;
    logic      valid_reg, valid_next;
    quantity_t quantity_reg;
    reading_t  reading_reg, reading_next;
    logic      last_reg;

    logic     load;
    logic [15:0] word;

    assign load = !q_status.empty && (!valid_reg || res.ready);
    assign pop  = load && (qty_reg == Q_PRESSURE);

    // Sensor words are big-endian: even byte high, odd byte low.
    assign word = {head[{qty_reg, 1'b0}], head[{qty_reg, 1'b1}]};

    always_comb
    begin
        case (qty_reg)
            Q_PRESSURE:
                reading_next = {1'b0, head[27], head[26], head[25], head[24]};
            default:
                reading_next = {{(READING_W-16){word[15]}}, word};
        endcase
        qty_next   = load ? ((qty_reg == Q_PRESSURE) ? '0 : qty_reg + 4'd1) : qty_reg;
        valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qty_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            qty_reg   <= qty_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quantity_reg <= qty_reg;
            reading_reg  <= reading_next;
            last_reg     <= (qty_reg == Q_PRESSURE);
        end
    end

    assign res.valid         = valid_reg;
    assign res.quantity      = quantity_reg;
    assign res.reading       = reading_reg;
    assign res.last_of_frame = last_reg;

endmodule

[src/ifd_checker.sv]
// Port-level assertions for the deframer, bound to its top level.
`include "imu_frame_deframer_macros.svh"

module ifd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input ifd_pkg::quantity_t  quantity,
    input ifd_pkg::reading_t   reading,
    input logic                last_of_frame
);
    import ifd_pkg::*;

    `IFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quantity) && $stable(reading), "result changed while stalled")
    `IFD_ASSERT_IMPL(a_last_flag, out_valid, last_of_frame == (quantity == Q_PRESSURE), "last_of_frame does not match pressure result")
    `IFD_ASSERT_IMPL(a_word_sign, out_valid && !last_of_frame, reading[32:15] == '0 || reading[32:15] == '1, "sensor word not sign extended")
    `IFD_ASSERT_IMPL(a_pressure_pos, out_valid && last_of_frame, !reading[32], "pressure has sign bit set")
    `IFD_ASSERT_NEXT(a_sequence, out_valid && out_ready && !last_of_frame, !out_valid || quantity == $past(quantity) + 4'd1, "quantities out of order within a frame")

endmodule

bind imu_frame_deframer ifd_checker u_ifd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .quantity      (res.quantity),
    .reading       (res.reading),
    .last_of_frame (res.last_of_frame)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the IMU frame deframer: framed byte streams against a parser model.
module tb_top;
    import ifd_pkg::*;

    // Byte target for the whole stream. Every queued byte counts, including
    // the directed bytes, noise bytes and payload bytes past the store.
    localparam int STREAM_BYTES  = 180;
    localparam int MIN_FRAMES    = 5;
    // Number of frames to queue before the sender waits for the output to drain.
    localparam int PAUSE_FRAME   = 3;
    // The frame at this position runs well past the end of the store.
    localparam int LONGEST_FRAME = 2;
    localparam int MAX_LENGTH    = 64;
    // Idle margin after the last predicted result has arrived, before the verdict.
    localparam int DRAIN_CYCLES  = 24;
    localparam int TIMEOUT_NS    = 1_000_000;
    // The pressure word takes the last four bytes of the store, least
    // significant byte first.
    localparam int PRESSURE_BYTE = 2 * Q_PRESSURE;

    // Where the parser stands in a frame.
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_PAYLOAD
    } parse_phase_e;

    // One byte waiting to be sent. The flag says whether idle cycles may follow it.
    typedef struct {
        byte_t rx_byte;
        logic  may_idle;
    } rx_item_t;

    typedef struct {
        quantity_t quantity;
        reading_t  reading;
        logic      last_of_frame;
    } sensor_result_t;

    logic clk;
    logic rst_n;

    ifd_byte_if   rx ();
    ifd_result_if res ();

    imu_frame_deframer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    // Our own copy of the parser state, updated on every accepted byte.
    parse_phase_e   shadow_phase;
    byte_t          shadow_length;
    byte_t          shadow_count;
    byte_t          shadow_store [FRAME_BYTES];

    rx_item_t       pending_bytes [$];
    sensor_result_t frame_results [$];

    logic rx_fire        = 1'b0;
    logic stalls_enabled = 1'b1;
    logic quiet_tail     = 1'b0;
    int   rx_gap         = 0;
    int   res_hold       = 0;
    int   failures       = 0;
    int   bytes_queued   = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // A frame end produces thirteen results from the store. Quantities 0 to 11
    // are big-endian byte pairs, sign-extended to the reading width. Quantity 12
    // is the little-endian pressure word, zero-extended.
    function automatic void decode_frame();
        sensor_result_t r;
        logic [15:0]    word;
        for (int q = 0; q < Q_PRESSURE; q++)
        begin
            word            = {shadow_store[2 * q], shadow_store[2 * q + 1]};
            r.quantity      = quantity_t'(q);
            r.reading       = {{(READING_W - 16){word[15]}}, word};
            r.last_of_frame = 1'b0;
            frame_results.push_back(r);
        end
        r.quantity      = Q_PRESSURE;
        r.reading       = {1'b0, shadow_store[PRESSURE_BYTE + 3], shadow_store[PRESSURE_BYTE + 2],
                           shadow_store[PRESSURE_BYTE + 1], shadow_store[PRESSURE_BYTE]};
        r.last_of_frame = 1'b1;
        frame_results.push_back(r);
    endfunction

    // One byte through the parser. While the parser waits for the second sync
    // byte, any other byte is skipped and the hunt does not start over. Once
    // the payload count equals the length, the next byte closes the frame. Its
    // value is never looked at. Payload bytes past the store still count toward
    // the length.
    function automatic void parse_byte(byte_t b);
        case (shadow_phase)
            HUNT_FIRST:
            begin
                if (b == SYNC_FIRST)
                begin
                    shadow_phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                if (b == SYNC_SECOND)
                begin
                    shadow_phase = TAKE_LENGTH;
                end
            end
            TAKE_LENGTH:
            begin
                shadow_length = b;
                shadow_count  = '0;
                shadow_phase  = TAKE_PAYLOAD;
            end
            default:
            begin
                if (shadow_count == shadow_length)
                begin
                    decode_frame();
                    shadow_phase = HUNT_FIRST;
                end
                else
                begin
                    if (shadow_count < FRAME_BYTES)
                    begin
                        shadow_store[shadow_count] = b;
                    end
                    shadow_count++;
                end
            end
        endcase
    endfunction

    function automatic void queue_byte(byte_t b);
        rx_item_t item;
        item.rx_byte  = b;
        item.may_idle = stalls_enabled;
        pending_bytes.push_back(item);
        bytes_queued++;
    endfunction

    // One frame with random content. It may have a few noise bytes in front.
    // Sometimes stray bytes sit between the two sync bytes. A noise byte can
    // itself be a sync byte, which shifts the framing. The shadow parser
    // follows that shift exactly like the block.
    task automatic queue_frame(int unsigned len);
        repeat ($urandom_range(0, 2)) queue_byte(byte_t'($urandom));
        queue_byte(SYNC_FIRST);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) queue_byte(byte_t'($urandom));
        end
        queue_byte(SYNC_SECOND);
        queue_byte(byte_t'(len));
        repeat (len) queue_byte(byte_t'($urandom));
        queue_byte(byte_t'($urandom));
    endtask

    // Returns once every queued byte has been transferred and every
    // predicted result has arrived.
    task automatic wait_for_results();
        while (pending_bytes.size() != 0 || rx.valid || frame_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Transfers are counted at the rising edge. An accepted byte goes through
    // the shadow parser. An accepted result is checked against the oldest
    // prediction. Both checks sit in one block, so the predictions for a
    // frame are always queued before its first result can show up.
    always @(posedge clk)
    begin : transfer_monitor
        sensor_result_t want;
        rx_fire = rst_n && rx.valid && rx.ready;
        if (rx_fire)
        begin
            parse_byte(rx.rx_byte);
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (frame_results.size() == 0)
            begin
                $error("result with none predicted: quantity %0d reading %0d last_of_frame %0b",
                       res.quantity, res.reading, res.last_of_frame);
                failures++;
            end
            else
            begin
                want = frame_results.pop_front();
                if (res.quantity !== want.quantity)
                begin
                    $error("quantity: expected %0d, actual %0d", want.quantity, res.quantity);
                    failures++;
                end
                if (res.reading !== want.reading)
                begin
                    $error("reading: expected %0d, actual %0d", want.reading, res.reading);
                    failures++;
                end
                if (res.last_of_frame !== want.last_of_frame)
                begin
                    $error("last_of_frame: expected %0b, actual %0b",
                           want.last_of_frame, res.last_of_frame);
                    failures++;
                end
            end
        end
    end

    // All inputs change at the falling edge. A byte is held until its transfer.
    // After it, a random burst of idle cycles may follow. The result side drops
    // ready in random bursts as well. Both kinds of idling stop once the quiet
    // tail of the stream has begun.
    always @(negedge clk)
    begin : stream_driver
        rx_item_t item;
        if (rst_n)
        begin
            if (!rx.valid || rx_fire)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    rx.valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    item = pending_bytes.pop_front();
                    rx.valid   <= 1'b1;
                    rx.rx_byte <= item.rx_byte;
                    quiet_tail = !item.may_idle;
                    if (item.may_idle && $urandom_range(0, 5) == 0)
                    begin
                        rx_gap = $urandom_range(1, 13);
                    end
                end
                else
                begin
                    rx.valid <= 1'b0;
                end
            end
            if (res_hold > 0)
            begin
                res_hold--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    res_hold = $urandom_range(1, 13);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned len;
        int unsigned pick;
        int          frames_queued;

        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.rx_byte = '0;
        res.ready  = 1'b0;

        shadow_phase  = HUNT_FIRST;
        shadow_length = '0;
        shadow_count  = '0;
        foreach (shadow_store[i])
        begin
            shadow_store[i] = '0;
        end

        // Reset is released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The hunt skips the second sync byte and any bytes that
        // are all zeros or all ones. Between the sync bytes, other bytes are
        // ignored, including a repeated first sync byte. A zero-length frame
        // decodes the store as reset left it. Its closing byte is a first sync
        // byte, which must not start a new hunt: the second sync byte after it
        // is skipped too. Then a short frame sets the extreme sensor words and
        // leaves the rest of the store unchanged.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SYNC_SECOND);
        queue_byte(SYNC_FIRST);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        queue_byte(8'h00);
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        queue_byte(SYNC_FIRST);
        queue_byte(SYNC_SECOND);
        queue_byte(8'd4);
        queue_byte(8'h80);
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'hFF);
        queue_byte(8'hFF);

        // Random frames. Most are short or fill the store, a few run past it,
        // and one runs well past it. Once, the sender stops until the output
        // has drained. The last stretch runs without any idling.
        frames_queued = 0;
        while (bytes_queued < STREAM_BYTES || frames_queued < MIN_FRAMES)
        begin
            if (frames_queued == PAUSE_FRAME)
            begin
                wait_for_results();
            end
            if (bytes_queued >= STREAM_BYTES - 40)
            begin
                stalls_enabled = 1'b0;
            end
            pick = $urandom_range(0, 9);
            if (frames_queued == LONGEST_FRAME)
            begin
                len = MAX_LENGTH;
            end
            else if (pick < 6)
            begin
                len = $urandom_range(0, FRAME_BYTES - 1);
            end
            else if (pick < 9)
            begin
                len = $urandom_range(FRAME_BYTES, FRAME_BYTES + 12);
            end
            else
            begin
                len = $urandom_range(FRAME_BYTES + 13, 80);
            end
            queue_frame(len);
            frames_queued++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS * 1ns);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
